// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mpm_pkg.sv =====
// Shared types, constants and helper function of the Mandelbrot pixel block.
`default_nettype none

package mpm_pkg;

	localparam int DEF_MAX_COLUMNS = 512;
	localparam int DEF_MAX_ROWS    = 256;
	localparam int FRACTION_BITS   = 28;

	localparam int COORD_W    = 32;
	localparam int STEP_W     = 31;
	localparam int ITER_W     = 16;
	localparam int ROW_LEN_W  = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = 64;
	localparam int MUL_W      = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN,
		REG_X_STEP,
		REG_Y_ORIGIN,
		REG_Y_STEP,
		REG_MAX_ITERATIONS,
		REG_ROW_LENGTH
	} reg_index_t;

	localparam logic signed [COORD_W-1:0] RST_X_ORIGIN = -32'sd671088640;
	localparam logic [STEP_W-1:0]         RST_X_STEP   = 31'd2243010;
	localparam logic signed [COORD_W-1:0] RST_Y_ORIGIN = -32'sd268435456;
	localparam logic [STEP_W-1:0]         RST_Y_STEP   = 31'd2284557;
	localparam logic [ITER_W-1:0]         RST_MAX_ITER = 16'd3000;
	localparam logic [ROW_LEN_W-1:0]      RST_ROW_LEN  = 10'd420;

	// Escape threshold of four in the product format; all ones when it does not fit.
	localparam logic [PROD_W:0] THRESHOLD = (2 * FRACTION_BITS + 2 < PROD_W) ?
		((PROD_W+1)'(1) << (2 * FRACTION_BITS + 2)) : {1'b0, {PROD_W{1'b1}}};

	localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [PROD_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[COORD_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mandelbrot_pixel_membership.sv =====
// Escape-time Mandelbrot membership test for one pixel, signed Q4.28 fixed point.
// The pixel is mapped to c and z is cleared; escape tests then run until the point
// escapes or the iteration limit is reached, and none run for a zero limit. Each test
// passes through the three multipliers (two shared with the pixel mapping), then through
// the compare and update. A new pixel is taken the cycle after its result is loaded.
// Reset loads the documented register defaults and clears all control state.
`default_nettype none

module mandelbrot_pixel_membership
	import mpm_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [CFG_IDX_W-1:0]          cfg_index,
	input  wire [CFG_DATA_W-1:0]         cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [$clog2(MAX_COLUMNS)-1:0] pixel_column,
	input  wire [$clog2(MAX_ROWS)-1:0]    pixel_row,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         inside_set,
	output logic                         row_end
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int EW = ((CW > ROW_LEN_W) ? CW : ROW_LEN_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_INIT,
		ST_MUL,
		ST_CHK,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] x_origin_q, y_origin_q;
	logic [STEP_W-1:0]         x_step_q, y_step_q;
	logic [ITER_W-1:0]         max_iter_q;
	logic [ROW_LEN_W-1:0]      row_len_q;

	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic signed [COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
	logic [ITER_W-1:0]         n_q;
	logic signed [PROD_W-1:0]  p0_q, p1_q, p2_q;
	logic                      res_inside_q, res_row_end_q;
	logic                      inside_q, row_end_q, out_valid_q;

	logic [CW-1:0]             col_sat;
	logic [RW-1:0]             row_sat;
	logic                      row_end_hit;
	logic signed [MUL_W-1:0]   ma0, mb0, ma1, mb1, ma2, mb2;
	logic signed [2*MUL_W-1:0] m0, m1, m2;
	logic [PROD_W:0]           mag;
	logic                      escape;
	logic                      last_iter;
	logic signed [PROD_W-1:0]  diff, re_next, im_next;
	logic signed [COORD_W-1:0] cr_map, ci_map;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= RST_X_ORIGIN;
			x_step_q   <= RST_X_STEP;
			y_origin_q <= RST_Y_ORIGIN;
			y_step_q   <= RST_Y_STEP;
			max_iter_q <= RST_MAX_ITER;
			row_len_q  <= RST_ROW_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN:       x_origin_q <= cfg_data;
				REG_X_STEP:         x_step_q   <= cfg_data[STEP_W-1:0];
				REG_Y_ORIGIN:       y_origin_q <= cfg_data;
				REG_Y_STEP:         y_step_q   <= cfg_data[STEP_W-1:0];
				REG_MAX_ITERATIONS: max_iter_q <= cfg_data[ITER_W-1:0];
				REG_ROW_LENGTH:     row_len_q  <= cfg_data[ROW_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_sat = ({1'b0, pixel_column} >= (CW+1)'(MAX_COLUMNS)) ?
			CW'(MAX_COLUMNS - 1) : pixel_column;
		row_sat = ({1'b0, pixel_row} >= (RW+1)'(MAX_ROWS)) ?
			RW'(MAX_ROWS - 1) : pixel_row;
		// A zero row length never matches, since column plus one is never zero.
		row_end_hit = (({{(EW-CW){1'b0}}, col_sat} + EW'(1)) ==
			{{(EW-ROW_LEN_W){1'b0}}, row_len_q});
	end

	// Two multipliers map the pixel to c in the map cycle and square z otherwise; the third forms zr*zi.
	always_comb begin
		if (state_q == ST_MAP) begin
			ma0 = $signed({2'b00, x_step_q});
			mb0 = $signed({{(MUL_W-CW){1'b0}}, col_q});
			ma1 = $signed({2'b00, y_step_q});
			mb1 = $signed({{(MUL_W-RW){1'b0}}, row_q});
		end else begin
			ma0 = $signed({zr_q[COORD_W-1], zr_q});
			mb0 = $signed({zr_q[COORD_W-1], zr_q});
			ma1 = $signed({zi_q[COORD_W-1], zi_q});
			mb1 = $signed({zi_q[COORD_W-1], zi_q});
		end
		ma2 = $signed({zr_q[COORD_W-1], zr_q});
		mb2 = $signed({zi_q[COORD_W-1], zi_q});
		m0 = ma0 * mb0;
		m1 = ma1 * mb1;
		m2 = ma2 * mb2;
	end

	always_comb begin
		cr_map    = sat32($signed({{(PROD_W-COORD_W){x_origin_q[COORD_W-1]}}, x_origin_q}) + p0_q);
		ci_map    = sat32($signed({{(PROD_W-COORD_W){y_origin_q[COORD_W-1]}}, y_origin_q}) + p1_q);
		mag       = {1'b0, $unsigned(p0_q)} + {1'b0, $unsigned(p1_q)};
		escape    = (mag > THRESHOLD);
		diff      = p0_q - p1_q;
		re_next   = (diff >>> FRACTION_BITS) +
			$signed({{(PROD_W-COORD_W){cr_q[COORD_W-1]}}, cr_q});
		im_next   = (p2_q >>> (FRACTION_BITS - 1)) +
			$signed({{(PROD_W-COORD_W){ci_q[COORD_W-1]}}, ci_q});
		last_iter = (({1'b0, n_q} + (ITER_W+1)'(1)) == {1'b0, max_iter_q});
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= col_sat;
				row_q <= row_sat;
			end
			ST_MAP, ST_MUL: begin
				p0_q <= m0[PROD_W-1:0];
				p1_q <= m1[PROD_W-1:0];
				p2_q <= m2[PROD_W-1:0];
			end
			ST_INIT: begin
				cr_q <= cr_map;
				ci_q <= ci_map;
				zr_q <= '0;
				zi_q <= '0;
				n_q  <= '0;
			end
			ST_CHK: begin
				if (!escape) begin
					zr_q <= sat32(re_next);
					zi_q <= sat32(im_next);
					n_q  <= n_q + ITER_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			inside_q      <= 1'b0;
			row_end_q     <= 1'b0;
			res_inside_q  <= 1'b0;
			res_row_end_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_row_end_q <= row_end_hit;
						state_q       <= ST_MAP;
					end
				end
				ST_MAP: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					if (max_iter_q == '0) begin
						res_inside_q <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (escape) begin
						res_inside_q <= 1'b0;
						state_q      <= ST_DONE;
					end else if (last_iter) begin
						res_inside_q <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						inside_q    <= res_inside_q;
						row_end_q   <= res_row_end_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign inside_set = inside_q;
	assign row_end    = row_end_q;

endmodule

`default_nettype wire

// ===== rtl/mpm_checker.sv =====
// Port-level checker for the Mandelbrot pixel block, with its bind statement.
`default_nettype none
`include "assert_macros.svh"

module mpm_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire inside_set,
	input wire row_end
);

	// A stalled result beat keeps its fields.
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(inside_set) && $stable(row_end), "result beat changed while stalled")

	// The block works on one pixel at a time.
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while a pixel is in work")

	// A result appears only at the end of a pixel's work.
	`CHK_SAME(a_result_from_work, clk, arst_n, $rose(out_valid), !$past(in_ready), "result beat without a pixel in work")

endmodule

bind mandelbrot_pixel_membership mpm_checker u_mpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.inside_set (inside_set),
	.row_end    (row_end)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Mandelbrot pixel membership block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mpm_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int NUM_DIRECTED = 31;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_PIXELS = 25;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
	localparam logic [64:0] ESCAPE_RADIUS_SQ = 65'd1 << (2 * FRACTION_BITS + 2);

	typedef enum logic {
		STEP_WRITE,
		STEP_PIXEL
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		reg_index_t index;
		logic [31:0] value;
		logic [8:0] col;
		logic [7:0] row;
		logic typed;
		logic in_set;
		logic row_end;
	} stim_row_t;

	typedef struct packed {
		logic [8:0] col;
		logic [7:0] row;
		logic in_set;
		logic row_end;
	} pixel_result_t;

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd0, 8'd0, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd419, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd255, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd251, 8'd117, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_MAX_ITERATIONS, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd0, 8'd0, 1'b1, 1'b1, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd419, 8'd200, 1'b1, 1'b1, 1'b1},
		'{STEP_WRITE, REG_ROW_LENGTH, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd255, 1'b1, 1'b1, 1'b0},
		'{STEP_WRITE, REG_ROW_LENGTH, 32'd1023, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd1, 1'b1, 1'b1, 1'b0},
		'{STEP_WRITE, REG_ROW_LENGTH, 32'd512, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd0, 1'b1, 1'b1, 1'b1},
		'{STEP_WRITE, REG_ROW_LENGTH, 32'd1, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd0, 8'd255, 1'b1, 1'b1, 1'b1},
		'{STEP_WRITE, REG_MAX_ITERATIONS, 32'd1, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd300, 8'd77, 1'b1, 1'b1, 1'b0},
		'{STEP_WRITE, REG_X_ORIGIN, 32'h7FFF_FFFF, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_X_STEP, 32'h7FFF_FFFF, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_Y_ORIGIN, 32'h8000_0000, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_Y_STEP, 32'h7FFF_FFFF, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_MAX_ITERATIONS, 32'd2, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd255, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd1, 8'd1, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_X_ORIGIN, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_X_STEP, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_Y_ORIGIN, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_Y_STEP, 32'd0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_MAX_ITERATIONS, 32'd65535, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL, REG_X_ORIGIN, 32'd0, 9'd511, 8'd255, 1'b1, 1'b1, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [8:0] pixel_column = '0;
	logic [7:0] pixel_row = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic inside_set;
	logic row_end;

	logic signed [31:0] x_origin_q = RST_X_ORIGIN;
	logic [30:0] x_step_q = RST_X_STEP;
	logic signed [31:0] y_origin_q = RST_Y_ORIGIN;
	logic [30:0] y_step_q = RST_Y_STEP;
	logic [15:0] max_iter_q = RST_MAX_ITER;
	logic [9:0] row_len_q = RST_ROW_LEN;

	pixel_result_t pending_results[$];
	pixel_result_t head;
	int mismatches = 0;
	int cycles = 0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int ready_gap = 0;
	int ready_pick;

	mandelbrot_pixel_membership u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.inside_set(inside_set),
		.row_end(row_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end else if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	function automatic pixel_result_t membership_of(input logic [8:0] col,
			input logic [7:0] row);
		pixel_result_t res;
		longint re_c, im_c, zr, zi, rr, ii, ri;
		logic [64:0] mag;
		int unsigned n;
		re_c = clamp_q(longint'(x_origin_q) + longint'(x_step_q) * longint'(col));
		im_c = clamp_q(longint'(y_origin_q) + longint'(y_step_q) * longint'(row));
		zr = 0;
		zi = 0;
		n = 0;
		while (n < max_iter_q) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			mag = {1'b0, rr} + {1'b0, ii};
			if (mag > ESCAPE_RADIUS_SQ) begin
				break;
			end
			zr = clamp_q(((rr - ii) >>> FRACTION_BITS) + re_c);
			zi = clamp_q((ri >>> (FRACTION_BITS - 1)) + im_c);
			n++;
		end
		res.col = col;
		res.row = row;
		res.in_set = (n == max_iter_q);
		res.row_end = (row_len_q != 0) && (col == row_len_q - 1);
		return res;
	endfunction

	function automatic int idle_gap();
		int roll;
		if (quiet) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 60);
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input reg_index_t index, input logic [31:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			REG_X_ORIGIN: x_origin_q = value;
			REG_X_STEP: x_step_q = value[30:0];
			REG_Y_ORIGIN: y_origin_q = value;
			REG_Y_STEP: y_step_q = value[30:0];
			REG_MAX_ITERATIONS: max_iter_q = value[15:0];
			REG_ROW_LENGTH: row_len_q = value[9:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [8:0] col, input logic [7:0] row,
			input logic typed, input logic in_set, input logic last_col);
		int gap;
		pixel_result_t want;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_column <= col;
		pixel_row <= row;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (typed) begin
			want = '{col, row, in_set, last_col};
		end else begin
			want = membership_of(col, row);
		end
		pending_results.push_back(want);
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
		end else if (ready_gap != 0) begin
			out_ready <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else begin
			ready_pick = idle_gap();
			out_ready <= (ready_pick == 0);
			if (ready_pick != 0) begin
				ready_gap <= ready_pick - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got inside_set %0b row_end %0b",
					$time, inside_set, row_end);
				mismatches++;
			end else begin
				head = pending_results.pop_front();
				if (inside_set !== head.in_set) begin
					$display("%0t: pixel (%0d,%0d) inside_set expected %0b, got %0b",
						$time, head.col, head.row, head.in_set, inside_set);
					mismatches++;
				end
				if (row_end !== head.row_end) begin
					$display("%0t: pixel (%0d,%0d) row_end expected %0b, got %0b",
						$time, head.col, head.row, head.row_end, row_end);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("mandelbrot_pixel_membership regression: fail");
			$finish;
		end
	end

	initial begin
		int k, p, j;
		logic [8:0] col;
		logic [7:0] row;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NUM_DIRECTED; k++) begin
			if (DIRECTED[k].kind == STEP_WRITE) begin
				write_reg(DIRECTED[k].index, DIRECTED[k].value);
			end else begin
				send_pixel(DIRECTED[k].col, DIRECTED[k].row, DIRECTED[k].typed,
					DIRECTED[k].in_set, DIRECTED[k].row_end);
			end
		end

		// Most phases look at a window around the set; every fourth one uses raw values.
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p % 4 == 2) begin
				write_reg(REG_X_ORIGIN, $urandom);
				write_reg(REG_X_STEP, $urandom);
				write_reg(REG_Y_ORIGIN, $urandom);
				write_reg(REG_Y_STEP, $urandom);
			end else begin
				write_reg(REG_X_ORIGIN, 32'hD800_0000 + $urandom_range(0, 32'h2000_0000));
				write_reg(REG_X_STEP, $urandom_range(0, 32'h0020_0000));
				write_reg(REG_Y_ORIGIN, 32'hE800_0000 + $urandom_range(0, 32'h1000_0000));
				write_reg(REG_Y_STEP, $urandom_range(0, 32'h0020_0000));
			end
			if (p == 5) begin
				write_reg(REG_MAX_ITERATIONS, 32'd255);
			end else if (p == 6) begin
				write_reg(REG_MAX_ITERATIONS, $urandom_range(0, 2));
			end else begin
				write_reg(REG_MAX_ITERATIONS, $urandom_range(1, 64));
			end
			if (p == 7) begin
				write_reg(REG_ROW_LENGTH, $urandom_range(0, 1023));
			end else begin
				write_reg(REG_ROW_LENGTH, $urandom_range(1, 512));
			end
			quiet <= (p == 3);
			if (p == 1) begin
				hold_req <= 1'b1;
			end
			for (j = 0; j < PHASE_PIXELS; j++) begin
				if (row_len_q >= 1 && row_len_q <= 512 && $urandom_range(0, 7) == 0) begin
					col = 9'(row_len_q - 1);
				end else begin
					col = 9'($urandom_range(0, 511));
				end
				row = 8'($urandom_range(0, 255));
				send_pixel(col, row, 1'b0, 1'b0, 1'b0);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("mandelbrot_pixel_membership regression: pass");
		end else begin
			$display("mandelbrot_pixel_membership regression: fail");
		end
		$finish;
	end

endmodule
